/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RPU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rpu_pkg.sv */
// package with format codes, group request type and group size helper
package rpu_pkg;

  localparam logic [3:0] FMT_8BIT     = 4'd0;
  localparam logic [3:0] FMT_12HIGH   = 4'd1;
  localparam logic [3:0] FMT_12LOW    = 4'd2;
  localparam logic [3:0] FMT_16HIGH   = 4'd3;
  localparam logic [3:0] FMT_16LOW    = 4'd4;
  localparam logic [3:0] FMT_16HIONLY = 4'd5;
  localparam logic [3:0] FMT_16LOONLY = 4'd6;
  localparam logic [3:0] FMT_12SBS    = 4'd7;
  localparam logic [3:0] FMT_RGB24    = 4'd8;

  // a complete group handed from the byte collector to the pixel stage
  typedef struct packed {
    logic [3:0] fmt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] bn;
  } grp_t;

  function automatic logic [1:0] group_size(input logic [3:0] fmt);
    logic [1:0] size;
    case (fmt)
      FMT_8BIT:     size = 2'd1;
      FMT_12HIGH:   size = 2'd2;
      FMT_12LOW:    size = 2'd2;
      FMT_16HIGH:   size = 2'd2;
      FMT_16LOW:    size = 2'd2;
      FMT_16HIONLY: size = 2'd2;
      FMT_16LOONLY: size = 2'd2;
      FMT_12SBS:    size = 2'd3;
      FMT_RGB24:    size = 2'd3;
      default:      size = 2'd0;
    endcase
    return size;
  endfunction

endpackage

/* design/rpu_collect.sv */
// byte collector: format register, partial group state and group register
module rpu_collect (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_pixel_format,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  output logic          grp_valid,
  input  logic          grp_ready,
  output rpu_pkg::grp_t grp
);

  logic [3:0]    fmt_r;
  logic [15:0]   held_r, held_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          grp_valid_r, grp_valid_nxt;
  rpu_pkg::grp_t grp_r, grp_nxt;
  logic [1:0]    size;
  logic          accept;

  assign size     = rpu_pkg::group_size(fmt_r);
  assign in_ready = !grp_valid_r || grp_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_nxt      = held_r;
    phase_nxt     = phase_r;
    grp_valid_nxt = grp_valid_r && !grp_ready;
    grp_nxt       = grp_r;
    if (accept) begin
      if (size == 2'd0) begin
        held_nxt  = '0;
        phase_nxt = '0;
      end else if ({1'b0, phase_r} + 3'd1 < {1'b0, size}) begin
        if (phase_r == 2'd0) begin
          held_nxt[7:0] = in_data_byte;
        end else begin
          held_nxt[15:8] = in_data_byte;
        end
        phase_nxt = phase_r + 2'd1;
      end else begin
        phase_nxt     = '0;
        grp_valid_nxt = 1'b1;
        grp_nxt.fmt   = fmt_r;
        grp_nxt.b0    = held_r[7:0];
        grp_nxt.b1    = held_r[15:8];
        grp_nxt.bn    = in_data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= rpu_pkg::FMT_8BIT;
      held_r      <= '0;
      phase_r     <= '0;
      grp_valid_r <= 1'b0;
    end else begin
      grp_valid_r <= grp_valid_nxt;
      if (cfg_we) begin
        fmt_r   <= cfg_pixel_format;
        held_r  <= '0;
        phase_r <= '0;
      end else begin
        held_r  <= held_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  assign grp_valid = grp_valid_r;
  assign grp       = grp_r;

endmodule

/* design/rpu_pixel.sv */
// pixel stage: unpacks a group into one or two pixels and holds them for output
module rpu_pixel (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_valid,
  output logic          grp_ready,
  input  rpu_pkg::grp_t grp,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [15:0]   out_pixel_value,
  output logic          out_last_of_group
);

  localparam logic [9:0] DIV3_MULT = 10'd683;

  logic        valid_r, valid_nxt;
  logic        two_r, two_nxt;
  logic [15:0] pix_a_r, pix_a_nxt;
  logic [15:0] pix_b_r, pix_b_nxt;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg;
  logic        load;
  logic        pop;

  // sum / 3 as a reciprocal multiply, exact for sums below 2048
  assign sum  = {2'b00, grp.b0} + {2'b00, grp.b1} + {2'b00, grp.bn};
  assign prod = {10'd0, sum} * {10'd0, DIV3_MULT};
  assign avg  = prod[18:11];

  assign pop       = valid_r && out_ready;
  assign grp_ready = !valid_r || (out_ready && !two_r);
  assign load      = grp_valid && grp_ready;

  always_comb begin
    pix_a_nxt = {4'd0, grp.b0, grp.b1[7:4]};
    case (grp.fmt)
      rpu_pkg::FMT_8BIT:     pix_b_nxt = {4'd0, grp.bn, 4'd0};
      rpu_pkg::FMT_12HIGH:   pix_b_nxt = {4'd0, grp.b0, grp.bn[7:4]};
      rpu_pkg::FMT_12LOW:    pix_b_nxt = {4'd0, grp.bn, grp.b0[7:4]};
      rpu_pkg::FMT_16HIGH:   pix_b_nxt = {grp.b0, grp.bn};
      rpu_pkg::FMT_16LOW:    pix_b_nxt = {grp.bn, grp.b0};
      rpu_pkg::FMT_16HIONLY: pix_b_nxt = {4'd0, grp.b0, 4'd0};
      rpu_pkg::FMT_16LOONLY: pix_b_nxt = {4'd0, grp.bn, 4'd0};
      rpu_pkg::FMT_12SBS:    pix_b_nxt = {4'd0, grp.bn, grp.b1[3:0]};
      rpu_pkg::FMT_RGB24:    pix_b_nxt = {4'd0, avg, 4'd0};
      default:               pix_b_nxt = '0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    two_nxt   = two_r;
    if (pop) begin
      if (two_r) begin
        two_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      two_nxt   = (grp.fmt == rpu_pkg::FMT_12SBS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      two_r   <= two_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_a_r <= pix_a_nxt;
      pix_b_r <= pix_b_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_value   = two_r ? pix_a_r : pix_b_r;
  assign out_last_of_group = !two_r;

endmodule

/* design/raw_pixel_unpacker.sv */
// top level of the raw pixel unpacker
// Takes one raw image byte per clock while in_ready is high and returns gray
// pixels in the packing chosen by cfg_pixel_format (8-bit, 12/16-bit pairs,
// 16-bit single byte, 12-bit side-by-side, rgb24 average). A byte that does
// not complete its group is held and gives no pixel; codes 9 to 15 drop every
// byte. A format write discards any partial group and must be done while the
// block is idle. A byte that completes a group passes through the group
// register, then the pixel register, before its first pixel appears. The input
// takes a byte every cycle; a side-by-side group gives two pixels for its three
// bytes, so a continuous stream runs at full rate as long as out_ready stays
// high, and pixel A of a side-by-side pair always comes with last_of_group low.
`include "assert_macros.svh"

module raw_pixel_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_pixel_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_value,
  output logic        out_last_of_group
);

  logic          grp_valid;
  logic          grp_ready;
  rpu_pkg::grp_t grp;

  rpu_collect u_collect (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_pixel_format (cfg_pixel_format),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .grp_valid        (grp_valid),
    .grp_ready        (grp_ready),
    .grp              (grp)
  );

  rpu_pixel u_pixel (
    .clk               (clk),
    .rst_n             (rst_n),
    .grp_valid         (grp_valid),
    .grp_ready         (grp_ready),
    .grp               (grp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_last_of_group (out_last_of_group)
  );

  `RPU_ASSERT_NEXT(a_pair_second, out_valid && out_ready && !out_last_of_group, out_valid && out_last_of_group, "second pixel of a side-by-side pair missing")
  `RPU_ASSERT_SAME(a_pair_blocks_load, out_valid && !out_last_of_group, !grp_ready, "group loaded while first pixel of a pair pending")
  `RPU_ASSERT_NEXT(a_grp_holds, grp_valid && !grp_ready, grp_valid && $stable(grp), "group request changed while stalled")

endmodule

/* sim/tb_raw_pixel_unpacker.sv */
// testbench for raw_pixel_unpacker: directed table then random bytes against a predictor
`timescale 1ns / 100ps

module tb_raw_pixel_unpacker;

  localparam logic [3:0] FMT_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] FMT_UNUSED_LAST  = 4'd15;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD     = 250;
  localparam int RANDOM_BYTES  = 800;
  localparam int HOLD_AT_BYTE  = 100;
  localparam int DIR_ROWS      = 36;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        last_of_group;
  } pixel_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_BYTE_EXP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  fmt;
    logic [7:0]  data;
    logic [15:0] exp_pixel;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [3:0]  cfg_pixel_format;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_pixel_value;
  logic        out_last_of_group;

  pixel_t     pixel_q [$];
  pixel_t     want;
  logic [3:0] fmt_model;
  logic [7:0] held_b0;
  logic [7:0] held_b1;
  int         phase_model;
  int         mismatches;
  int         cycles;
  int         random_bytes;
  bit         send_calm;
  bit         hold_req;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE_EXP, rpu_pkg::FMT_8BIT,     8'h00, 16'h0000},
    '{ROW_BYTE_EXP, rpu_pkg::FMT_8BIT,     8'hFF, 16'h0FF0},
    '{ROW_CFG,      rpu_pkg::FMT_12HIGH,   8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12HIGH,   8'hFF, 16'h0000},
    '{ROW_BYTE_EXP, rpu_pkg::FMT_12HIGH,   8'hFF, 16'h0FFF},
    '{ROW_CFG,      rpu_pkg::FMT_12LOW,    8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12LOW,    8'hA5, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12LOW,    8'h3C, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_16HIGH,   8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16HIGH,   8'hFF, 16'h0000},
    '{ROW_BYTE_EXP, rpu_pkg::FMT_16HIGH,   8'hFF, 16'hFFFF},
    '{ROW_CFG,      rpu_pkg::FMT_16LOW,    8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16LOW,    8'h12, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16LOW,    8'h34, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_16HIONLY, 8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16HIONLY, 8'hAB, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16HIONLY, 8'hCD, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_16LOONLY, 8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16LOONLY, 8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16LOONLY, 8'hFF, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_12SBS,    8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12SBS,    8'hAB, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12SBS,    8'hCD, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_12SBS,    8'hEF, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_RGB24,    8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_RGB24,    8'hFF, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_RGB24,    8'hFF, 16'h0000},
    '{ROW_BYTE_EXP, rpu_pkg::FMT_RGB24,    8'hFF, 16'h0FF0},
    '{ROW_BYTE,     rpu_pkg::FMT_RGB24,    8'h00, 16'h0000},
    '{ROW_CFG,      rpu_pkg::FMT_16HIGH,   8'h00, 16'h0000},
    '{ROW_BYTE,     rpu_pkg::FMT_16HIGH,   8'h11, 16'h0000},
    '{ROW_BYTE_EXP, rpu_pkg::FMT_16HIGH,   8'h22, 16'h1122},
    '{ROW_CFG,      FMT_UNUSED_LAST,       8'h00, 16'h0000},
    '{ROW_BYTE,     FMT_UNUSED_LAST,       8'hFF, 16'h0000},
    '{ROW_CFG,      FMT_UNUSED_FIRST,      8'h00, 16'h0000},
    '{ROW_BYTE,     FMT_UNUSED_FIRST,      8'h01, 16'h0000}
  };

  raw_pixel_unpacker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_pixel_format  (cfg_pixel_format),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_last_of_group (out_last_of_group)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(3, 1);
    end
    if (r < 98) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(40, 15);
  endfunction

  function automatic logic [15:0] nibble_shift(input logic [7:0] b);
    return {4'h0, b, 4'h0};
  endfunction

  // advances the unpacking state by one byte and queues the pixels it completes when keep is set
  function automatic void unpack_byte(input logic [7:0] b, input bit keep);
    int         size;
    logic [9:0] sum;
    logic [9:0] avg;
    pixel_t     px [2];
    int         n;
    n = 0;
    case (fmt_model)
      rpu_pkg::FMT_8BIT:                          size = 1;
      rpu_pkg::FMT_12HIGH, rpu_pkg::FMT_12LOW, rpu_pkg::FMT_16HIGH,
      rpu_pkg::FMT_16LOW, rpu_pkg::FMT_16HIONLY,
      rpu_pkg::FMT_16LOONLY:                      size = 2;
      rpu_pkg::FMT_12SBS, rpu_pkg::FMT_RGB24:     size = 3;
      default:                                    size = 0;
    endcase
    if (size == 0) begin
      phase_model = 0;
      held_b0 = 8'h00;
      held_b1 = 8'h00;
    end else if (phase_model + 1 < size) begin
      if (phase_model == 0) begin
        held_b0 = b;
      end else begin
        held_b1 = b;
      end
      phase_model = phase_model + 1;
    end else begin
      phase_model = 0;
      n = 1;
      px[0].last_of_group = 1'b1;
      case (fmt_model)
        rpu_pkg::FMT_8BIT:     px[0].pixel_value = nibble_shift(b);
        rpu_pkg::FMT_12HIGH:   px[0].pixel_value = {4'h0, held_b0, b[7:4]};
        rpu_pkg::FMT_12LOW:    px[0].pixel_value = {4'h0, b, held_b0[7:4]};
        rpu_pkg::FMT_16HIGH:   px[0].pixel_value = {held_b0, b};
        rpu_pkg::FMT_16LOW:    px[0].pixel_value = {b, held_b0};
        rpu_pkg::FMT_16HIONLY: px[0].pixel_value = nibble_shift(held_b0);
        rpu_pkg::FMT_16LOONLY: px[0].pixel_value = nibble_shift(b);
        rpu_pkg::FMT_12SBS: begin
          px[0].pixel_value = {4'h0, held_b0, held_b1[7:4]};
          px[0].last_of_group = 1'b0;
          px[1].pixel_value = {4'h0, b, held_b1[3:0]};
          px[1].last_of_group = 1'b1;
          n = 2;
        end
        default: begin
          sum = {2'b00, held_b0} + {2'b00, held_b1} + {2'b00, b};
          avg = sum / 10'd3;
          px[0].pixel_value = nibble_shift(avg[7:0]);
        end
      endcase
    end
    if (keep) begin
      for (int i = 0; i < n; i++) begin
        pixel_q.push_back(px[i]);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [15:0] exp_pixel);
    int gap;
    if ($urandom_range(149, 0) == 0) begin
      send_calm = !send_calm;
    end
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    unpack_byte(b, !typed);
    if (typed) begin
      pixel_q.push_back({exp_pixel, 1'b1});
    end
    @(negedge clk);
  endtask

  task automatic write_format(input logic [3:0] f);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_pixel_format <= f;
    fmt_model = f;
    held_b0 = 8'h00;
    held_b1 = 8'h00;
    phase_model = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver side: random back-pressure plus one long hold
  initial begin
    int gap_left;
    int hold_left;
    bit recv_calm;
    bit hold_done;
    gap_left = 0;
    hold_left = 0;
    recv_calm = 1'b0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199, 0) == 0) begin
        recv_calm = !recv_calm;
      end
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        gap_left = pick_gap(recv_calm);
        out_ready <= (gap_left == 0);
        if (gap_left > 0) begin
          gap_left--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel with no request pending: pixel_value %h last_of_group %b",
               out_pixel_value, out_last_of_group);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_value !== want.pixel_value) begin
          $error("pixel_value expected %h actual %h", want.pixel_value, out_pixel_value);
          mismatches++;
        end
        if (out_last_of_group !== want.last_of_group) begin
          $error("last_of_group expected %b actual %b", want.last_of_group,
                 out_last_of_group);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] f;
    int         n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_pixel_format = rpu_pkg::FMT_8BIT;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    fmt_model = rpu_pkg::FMT_8BIT;
    held_b0 = 8'h00;
    held_b1 = 8'h00;
    phase_model = 0;
    mismatches = 0;
    cycles = 0;
    random_bytes = 0;
    send_calm = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_format(dir_rows[i].fmt);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].kind == ROW_BYTE_EXP, dir_rows[i].exp_pixel);
      end
    end

    while (random_bytes < RANDOM_BYTES) begin
      f = 4'($urandom_range(9, 0));
      if (f == FMT_UNUSED_FIRST) begin
        f = 4'($urandom_range(FMT_UNUSED_LAST, FMT_UNUSED_FIRST));
      end
      write_format(f);
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 4);
      for (int k = 0; k < n; k++) begin
        send_byte(8'($urandom_range(255, 0)), 1'b0, 16'h0000);
        if (f <= rpu_pkg::FMT_RGB24) begin
          random_bytes++;
          if (random_bytes == HOLD_AT_BYTE) begin
            hold_req = 1'b1;
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/rpu_pkg.sv
design/rpu_collect.sv
design/rpu_pixel.sv
design/raw_pixel_unpacker.sv
sim/tb_raw_pixel_unpacker.sv
